// ----- rtl/pgs_pkg.sv -----
// Shared types and constants of the point gravity step block.
package pgs_pkg;

  localparam int unsigned MaxAttractors = 16;
  localparam int unsigned SlotW = $clog2(MaxAttractors);
  localparam int unsigned CountW = $clog2(MaxAttractors + 1);

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_STAR = 2'd1;
  localparam logic [1:0] MODE_BODY = 2'd2;

  localparam logic [1:0] CFG_TIME_STEP = 2'd0;
  localparam logic [1:0] CFG_DAMPING = 2'd1;
  localparam logic [1:0] CFG_SOFTENING = 2'd2;
  localparam logic [1:0] CFG_COUNT = 2'd3;

  localparam logic [31:0] TimeStepReset = 32'd65536;
  localparam logic [16:0] DampingReset = 17'd65536;
  localparam logic [31:0] SofteningReset = 32'd327680;
  localparam logic [16:0] QOne = 17'd65536;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [30:0] mass;
  } pgs_in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic saturated;
  } pgs_out_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0] mass;
  } pgs_attr_t;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_DIFF, S_SQR, S_SUM, S_ROOT, S_ROOT_W, S_GDIV, S_GDIV_W,
    S_PROD, S_QDIV, S_QDIV_W, S_ACC, S_F_TS, S_F_VEL, S_F_DAMP, S_F_PTS,
    S_F_POS, S_DONE
  } pgs_state_e;

endpackage

// ----- rtl/pgs_ram.sv -----
// Synchronous single-port-write, single-port-read memory with registered read data.
module pgs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- rtl/pgs_sqrt.sv -----
// Bit-serial floor square root of a 66-bit value, two operand bits per cycle.
module pgs_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [65:0] op_i,
  output logic        done_o,
  output logic [32:0] root_o
);
  logic [36:0] rem_q;
  logic [32:0] root_q;
  logic [65:0] op_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [36:0] rem_sh, trial;
  logic        fits;

  assign rem_sh = {rem_q[34:0], op_q[65:64]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd33;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q   <= op_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      op_q <= {op_q[63:0], 2'b00};
      if (fits) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[31:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[31:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// ----- rtl/pgs_div.sv -----
// Restoring divider, one quotient bit per cycle, 47-bit dividend by 34-bit divisor.
module pgs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [46:0] num_i,
  input  logic [33:0] den_i,
  output logic        done_o,
  output logic [46:0] quot_o
);
  logic [33:0] rem_q;
  logic [33:0] den_q;
  logic [46:0] num_q;
  logic [46:0] quot_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [34:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_q, num_q[46]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd47;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[45:0], 1'b0};
      if (fits) begin
        rem_q  <= 34'(rem_sh - {1'b0, den_q});
        quot_q <= {quot_q[45:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[33:0];
        quot_q <= {quot_q[45:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

// ----- rtl/point_gravity_step.sv -----
// Top level of the point gravity step block: attractor table, sequencer and datapath.
// A load item is written to the table in the cycle it is accepted and busy stays low. An
// advance item keeps busy high while each active attractor runs through the bit-serial
// square root and the shared one-bit-per-cycle divider, which is used four times per
// attractor farther than 1.0; attractors at distance 1.0 or less skip the divider.
// The result appears with result_valid_o for one cycle, in the last cycle of busy, and
// must be taken then since the receiver cannot stall it.
module point_gravity_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  pgs_pkg::pgs_in_t    item_i,
  output logic                result_valid_o,
  output pgs_pkg::pgs_out_t   result_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);
  import pgs_pkg::*;

  function automatic logic signed [48:0] mul_q16(logic signed [31:0] a, logic [31:0] b);
    logic [31:0] mag;
    logic [47:0] p;
    mag = a[31] ? 32'(-a) : 32'(a);
    p   = 48'(({32'b0, mag} * {32'b0, b}) >> 16);
    return a[31] ? -$signed({1'b0, p}) : $signed({1'b0, p});
  endfunction

  function automatic logic [32:0] clamp32(logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      return {1'b1, 32'h7fffffff};
    end else if (v < -50'sd2147483648) begin
      return {1'b1, 32'h80000000};
    end
    return {1'b0, v[31:0]};
  endfunction

  pgs_state_e state_q, state_d;

  logic [31:0] ts_q, soft_q;
  logic [16:0] damp_q;
  logic [4:0]  count_q;

  pgs_in_t     item_q;
  logic [CountW-1:0] idx_q, n_q;
  logic [1:0]  comp_q;
  logic signed [32:0] d_q [3];
  logic [63:0] sq_q [3];
  logic [65:0] sumsq_q;
  logic [32:0] r_q;
  logic [30:0] g_q;
  logic [46:0] prod_q;
  logic signed [37:0] force_q [3];
  logic signed [48:0] tf_q;
  logic signed [31:0] v_q;
  logic signed [48:0] tp_q;
  logic signed [31:0] res_pos_q [3];
  logic signed [31:0] res_vel_q [3];
  logic        sat_q;

  logic        accept, load_we;
  pgs_attr_t   wr_attr, rd_attr;
  logic        sq_start, sq_done;
  logic [32:0] sq_root;
  logic        dv_start, dv_done;
  logic [46:0] dv_num, dv_quot;
  logic [33:0] dv_den;
  logic signed [31:0] rd_pos [3];
  logic signed [31:0] it_pos [3];
  logic signed [31:0] it_vel [3];
  logic [31:0] mag;
  logic [CountW-1:0] idx_n, n_cap;
  logic [16:0] damp_eff;
  logic [32:0] f_cl, v_cl, p_cl;

  assign accept  = start && !busy;
  assign load_we = accept && (item_i.mode == MODE_LOAD);
  assign wr_attr = '{pos_x: item_i.pos_x, pos_y: item_i.pos_y, pos_z: item_i.pos_z,
                     mass: item_i.mass};

  pgs_ram #(.Width($bits(pgs_attr_t)), .Depth(MaxAttractors)) u_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (item_i.slot[SlotW-1:0]),
    .wdata_i (wr_attr),
    .raddr_i (idx_q[SlotW-1:0]),
    .rdata_o (rd_attr)
  );

  pgs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .op_i    (sumsq_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign dv_num = (state_q == S_GDIV) ? {rd_attr.mass, 16'b0} : prod_q;
  assign dv_den = (state_q == S_GDIV) ? 34'({1'b0, r_q} + {2'b0, soft_q}) : {1'b0, r_q};
  assign dv_start = (state_q == S_GDIV) || (state_q == S_QDIV);
  assign sq_start = (state_q == S_ROOT);

  pgs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .done_o  (dv_done),
    .quot_o  (dv_quot)
  );

  assign rd_pos = '{rd_attr.pos_x, rd_attr.pos_y, rd_attr.pos_z};
  assign it_pos = '{item_q.pos_x, item_q.pos_y, item_q.pos_z};
  assign it_vel = '{item_q.vel_x, item_q.vel_y, item_q.vel_z};
  assign mag    = d_q[comp_q][32] ? 32'(-d_q[comp_q]) : 32'(d_q[comp_q]);
  assign idx_n  = idx_q + CountW'(1);
  assign n_cap  = (count_q > 5'(MaxAttractors)) ? CountW'(MaxAttractors) : CountW'(count_q);
  assign damp_eff = (damp_q > QOne) ? QOne : damp_q;
  assign f_cl   = clamp32(50'(force_q[comp_q]));
  assign v_cl   = clamp32(50'(it_vel[comp_q]) + 50'(tf_q));
  assign p_cl   = clamp32(50'(it_pos[comp_q]) + 50'(tp_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q    <= TimeStepReset;
      damp_q  <= DampingReset;
      soft_q  <= SofteningReset;
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIME_STEP: ts_q    <= cfg_data_i;
        CFG_DAMPING:   damp_q  <= cfg_data_i[16:0];
        CFG_SOFTENING: soft_q  <= cfg_data_i;
        CFG_COUNT:     count_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (item_i.mode == MODE_STAR || item_i.mode == MODE_BODY)) begin
          state_d = (n_cap == '0) ? S_F_TS : S_READ;
        end
      end
      S_READ:   state_d = S_DIFF;
      S_DIFF:   state_d = S_SQR;
      S_SQR:    state_d = S_SUM;
      S_SUM:    state_d = S_ROOT;
      S_ROOT:   state_d = S_ROOT_W;
      S_ROOT_W: begin
        if (sq_done) begin
          if (sq_root <= 33'(QOne)) begin
            state_d = (idx_n == n_q) ? S_F_TS : S_READ;
          end else begin
            state_d = S_GDIV;
          end
        end
      end
      S_GDIV:   state_d = S_GDIV_W;
      S_GDIV_W: if (dv_done) state_d = S_PROD;
      S_PROD:   state_d = S_QDIV;
      S_QDIV:   state_d = S_QDIV_W;
      S_QDIV_W: if (dv_done) state_d = S_ACC;
      S_ACC: begin
        if (comp_q != 2'd2) begin
          state_d = S_PROD;
        end else begin
          state_d = (idx_n == n_q) ? S_F_TS : S_READ;
        end
      end
      S_F_TS:   state_d = S_F_VEL;
      S_F_VEL:  state_d = S_F_DAMP;
      S_F_DAMP: state_d = S_F_PTS;
      S_F_PTS:  state_d = S_F_POS;
      S_F_POS:  state_d = (comp_q == 2'd2) ? S_DONE : S_F_TS;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        item_q  <= item_i;
        idx_q   <= '0;
        n_q     <= n_cap;
        comp_q  <= '0;
        sat_q   <= 1'b0;
        force_q <= '{default: '0};
      end
      S_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          d_q[i] <= {rd_pos[i][31], rd_pos[i]} - {it_pos[i][31], it_pos[i]};
        end
      end
      S_SQR: begin
        for (int i = 0; i < 3; i++) begin
          sq_q[i] <= d_q[i][32] ? ({32'b0, 32'(-d_q[i])} * {32'b0, 32'(-d_q[i])})
                                : ({32'b0, 32'(d_q[i])} * {32'b0, 32'(d_q[i])});
        end
      end
      S_SUM: sumsq_q <= {2'b0, sq_q[0]} + {2'b0, sq_q[1]} + {2'b0, sq_q[2]};
      S_ROOT_W: begin
        if (sq_done) begin
          r_q    <= sq_root;
          comp_q <= '0;
          if (sq_root <= 33'(QOne)) begin
            idx_q <= idx_n;
          end
        end
      end
      S_GDIV_W: if (dv_done) g_q <= dv_quot[30:0];
      S_PROD:   prod_q <= 47'({32'b0, mag} * {33'b0, g_q});
      S_ACC: begin
        force_q[comp_q] <= d_q[comp_q][32] ? force_q[comp_q] - 38'(dv_quot[30:0])
                                           : force_q[comp_q] + 38'(dv_quot[30:0]);
        if (comp_q == 2'd2) begin
          comp_q <= '0;
          idx_q  <= idx_n;
        end else begin
          comp_q <= comp_q + 2'd1;
        end
      end
      S_F_TS: begin
        tf_q  <= mul_q16($signed(f_cl[31:0]), ts_q);
        sat_q <= sat_q | f_cl[32];
      end
      S_F_VEL: begin
        v_q   <= $signed(v_cl[31:0]);
        sat_q <= sat_q | v_cl[32];
      end
      S_F_DAMP: begin
        if (item_q.mode == MODE_BODY) begin
          v_q <= 32'(mul_q16(v_q, {15'b0, damp_eff}));
        end
      end
      S_F_PTS: tp_q <= mul_q16(v_q, ts_q);
      S_F_POS: begin
        res_pos_q[comp_q] <= $signed(p_cl[31:0]);
        res_vel_q[comp_q] <= v_q;
        sat_q             <= sat_q | p_cl[32];
        comp_q            <= comp_q + 2'd1;
      end
      default: ;
    endcase
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_DONE);
  assign result_o = '{new_pos_x: res_pos_q[0], new_pos_y: res_pos_q[1],
                      new_pos_z: res_pos_q[2], new_vel_x: res_vel_q[0],
                      new_vel_y: res_vel_q[1], new_vel_z: res_vel_q[2],
                      saturated: sat_q};
endmodule

// ----- rtl/pgs_checker.sv -----
// Port-level checks of the point gravity step block and their binding to the top level.
module pgs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input pgs_pkg::pgs_in_t  item_i,
  input logic              result_valid_o
);
  import pgs_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe lasted more than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result shown while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.mode == MODE_LOAD) |=> !busy)
    else $error("load transfer left the block busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.mode == MODE_STAR || item_i.mode == MODE_BODY)) |=> busy)
    else $error("advance transfer did not start work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !result_valid_o) |=> busy)
    else $error("work ended without a result");
endmodule

bind point_gravity_step pgs_checker u_pgs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_valid_o (result_valid_o)
);

// ----- sim/point_gravity_step_tb.sv -----
// Self-checking testbench for the point gravity step block: directed table, then random phases.
module point_gravity_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pgs_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam longint unsigned CycleLimit = 40_000_000;
  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  pgs_in_t item_q = '0;
  logic result_valid_o;
  pgs_out_t result_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_TIME_STEP;
  logic [31:0] cfg_data_i = '0;

  point_gravity_step uut (
    .clk_i, .rst_ni, .start, .busy, .item_i(item_q), .result_valid_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  bit [31:0] step_r = TimeStepReset;
  bit [16:0] damp_r = DampingReset;
  bit [31:0] soft_r = SofteningReset;
  bit [4:0] count_r = '0;
  pgs_attr_t attr_tab [MaxAttractors];
  bit clamp_hit;

  pgs_out_t motion_q[$];
  int unsigned mismatches = 0;
  int unsigned n_loads = 0, n_advances = 0, n_results = 0;
  longint unsigned cycles = 0;

  function automatic longint scale_q16(longint a, longint unsigned b);
    longint unsigned mag = (a < 0) ? longint'(-a) : longint'(a);
    longint unsigned prod = (mag * b) >> 16;
    return (a < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic longint clamp_word(longint v);
    if (v > QMax) begin
      clamp_hit = 1'b1;
      return QMax;
    end
    if (v < QMin) begin
      clamp_hit = 1'b1;
      return QMin;
    end
    return v;
  endfunction

  function automatic bit [32:0] root66(bit [65:0] v);
    bit [32:0] root = '0;
    bit [67:0] trial;
    for (int b = 32; b >= 0; b--) begin
      trial = 68'(root | (33'd1 << b));
      if (trial * trial <= 68'(v)) root = trial[32:0];
    end
    return root;
  endfunction

  // Returns 1 when the item produces a motion update.
  function automatic bit predict_motion(pgs_in_t it, output pgs_out_t res);
    longint p [3], v [3], f [3], d [3];
    longint unsigned mag, g, q, dm;
    bit [65:0] dist_sq;
    bit [32:0] r;
    int n;
    res = '0;
    if (it.mode == MODE_LOAD) begin
      attr_tab[it.slot] = '{it.pos_x, it.pos_y, it.pos_z, it.mass};
      return 1'b0;
    end
    if (it.mode != MODE_STAR && it.mode != MODE_BODY) return 1'b0;
    p = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
    v = '{longint'(it.vel_x), longint'(it.vel_y), longint'(it.vel_z)};
    f = '{0, 0, 0};
    n = (count_r > MaxAttractors) ? MaxAttractors : count_r;
    for (int a = 0; a < n; a++) begin
      d[0] = longint'(attr_tab[a].pos_x) - p[0];
      d[1] = longint'(attr_tab[a].pos_y) - p[1];
      d[2] = longint'(attr_tab[a].pos_z) - p[2];
      dist_sq = '0;
      for (int i = 0; i < 3; i++) begin
        mag = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
        dist_sq += 66'(mag) * 66'(mag);
      end
      r = root66(dist_sq);
      if (r <= QOne) continue;
      g = (64'(attr_tab[a].mass) << 16) / (64'(r) + 64'(soft_r));
      for (int i = 0; i < 3; i++) begin
        mag = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
        q = (mag * g) / 64'(r);
        f[i] += (d[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
    dm = (damp_r > QOne) ? QOne : damp_r;
    clamp_hit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      v[i] = clamp_word(v[i] + scale_q16(clamp_word(f[i]), step_r));
      if (it.mode == MODE_BODY) v[i] = scale_q16(v[i], dm);
      p[i] = clamp_word(p[i] + scale_q16(v[i], step_r));
    end
    res.new_pos_x = p[0][31:0];
    res.new_pos_y = p[1][31:0];
    res.new_pos_z = p[2][31:0];
    res.new_vel_x = v[0][31:0];
    res.new_vel_y = v[1][31:0];
    res.new_vel_z = v[2][31:0];
    res.saturated = clamp_hit;
    return 1'b1;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    pgs_out_t w;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("point_gravity_step_tb: errors");
      $finish;
    end else if (rst_ni && result_valid_o) begin
      n_results++;
      if (motion_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", result_o);
      end else begin
        w = motion_q.pop_front();
        check_field("new_pos_x", w.new_pos_x, result_o.new_pos_x);
        check_field("new_pos_y", w.new_pos_y, result_o.new_pos_y);
        check_field("new_pos_z", w.new_pos_z, result_o.new_pos_z);
        check_field("new_vel_x", w.new_vel_x, result_o.new_vel_x);
        check_field("new_vel_y", w.new_vel_y, result_o.new_vel_y);
        check_field("new_vel_z", w.new_vel_z, result_o.new_vel_z);
        check_field("saturated", 32'(w.saturated), 32'(result_o.saturated));
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer with start high.
  task automatic send(pgs_in_t it, bit typed = 1'b0, pgs_out_t want = '0);
    pgs_out_t r;
    while (busy) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    item_q <= it;
    start <= 1'b1;
    if (it.mode == MODE_LOAD) n_loads++;
    if (predict_motion(it, r)) begin
      n_advances++;
      motion_q.push_back(typed ? want : r);
    end
    @(negedge clk_i);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(negedge clk_i);
    while (motion_q.size() != 0 || busy) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_TIME_STEP: step_r = data;
      CFG_DAMPING:   damp_r = data[16:0];
      CFG_SOFTENING: soft_r = data;
      CFG_COUNT:     count_r = data[4:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic pgs_in_t make_item(logic [1:0] mode, logic [3:0] slot,
                                        logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                        logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                        logic [30:0] mass);
    return '{mode, slot, px, py, pz, vx, vy, vz, mass};
  endfunction

  function automatic pgs_out_t make_motion(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                           logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                           logic sat);
    return '{px, py, pz, vx, vy, vz, sat};
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      6, 7, 8: return $urandom;
      9: begin
        case ($urandom_range(0, 2))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          default: return 32'h0;
        endcase
      end
      default: return 32'($urandom_range(0, 32'h00800000)) - 32'h00400000;
    endcase
  endfunction

  function automatic logic [30:0] rand_mass();
    case ($urandom_range(0, 5))
      0: return 31'h7fffffff;
      1: return 31'($urandom);
      default: return 31'($urandom_range(0, 32'h00ffffff));
    endcase
  endfunction

  function automatic logic [31:0] near(logic [31:0] c);
    return ($urandom_range(0, 3) == 0) ? c : c + 32'($urandom_range(0, 32'h0003ffff)) - 32'h1ffff;
  endfunction

  typedef struct {
    pgs_in_t  it;
    bit       typed;
    pgs_out_t want;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    pgs_in_t it;
    int unsigned burst, n_items, j, n_phases;
    logic [1:0] m;
    n_phases = 9;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    rows.push_back('{make_item(MODE_STAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                     make_motion(0, 0, 0, 0, 0, 0, 1'b0)});
    rows.push_back('{make_item(MODE_STAR, 4'hf, 0, 0, 0, 32'h10000, 32'hffff0000, 32'h20000,
                               31'h7fffffff), 1'b1,
                     make_motion(32'h10000, 32'hffff0000, 32'h20000,
                                 32'h10000, 32'hffff0000, 32'h20000, 1'b0)});
    rows.push_back('{make_item(MODE_STAR, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0), 1'b1,
                     make_motion(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1)});
    rows.push_back('{make_item(MODE_STAR, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h80000000, 32'h80000000, 0), 1'b1,
                     make_motion(32'h80000000, 32'h80000000, 32'h80000000,
                                 32'h80000000, 32'h80000000, 32'h80000000, 1'b1)});
    rows.push_back('{make_item(MODE_BODY, 0, 0, 0, 0, 32'h10000, 32'hffff0000, 32'h20000, 0),
                     1'b1, make_motion(32'h10000, 32'hffff0000, 32'h20000,
                                       32'h10000, 32'hffff0000, 32'h20000, 1'b0)});
    rows.push_back('{make_item(MODE_NONE, 4'h5, 32'h12345678, 0, 0, 0, 0, 0, 31'h55), 1'b0, '0});
    for (int s = 0; s < MaxAttractors; s++) begin
      case (s)
        0: it = make_item(MODE_LOAD, 4'(s), 32'h00050000, 0, 0, 32'hffffffff, 32'hffffffff,
                          32'hffffffff, 31'h7fffffff);
        1: it = make_item(MODE_LOAD, 4'(s), 0, 32'hfff80000, 0, 0, 0, 0, 0);
        14: it = make_item(MODE_LOAD, 4'(s), 32'h80000000, 32'h80000000, 32'h80000000,
                           0, 0, 0, 31'h00010000);
        15: it = make_item(MODE_LOAD, 4'(s), 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           0, 0, 0, 31'h40000000);
        default: it = make_item(MODE_LOAD, 4'(s), 32'(s) << 18, -(32'(s) << 17), 32'(s) << 16,
                                0, 0, 0, 31'(s) << 20);
      endcase
      rows.push_back('{it, 1'b0, '0});
    end
    foreach (rows[k]) send(rows[k].it, rows[k].typed, rows[k].want);

    for (int ph = 0; ph < n_phases; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(CFG_COUNT, 32'd31);
          write_reg(CFG_DAMPING, 32'h1ffff);
          write_reg(CFG_SOFTENING, 32'h0);
          write_reg(CFG_TIME_STEP, 32'h10000);
        end
        1: begin
          write_reg(CFG_COUNT, 32'd16);
          write_reg(CFG_DAMPING, 32'h0);
          write_reg(CFG_SOFTENING, 32'hffffffff);
          write_reg(CFG_TIME_STEP, 32'hffffffff);
        end
        2: begin
          write_reg(CFG_COUNT, 32'd0);
          write_reg(CFG_TIME_STEP, 32'h0);
          write_reg(CFG_DAMPING, 32'h10000);
        end
        default: begin
          write_reg(CFG_COUNT, $urandom_range(1, 5));
          write_reg(CFG_DAMPING, $urandom_range(0, 32'h1ffff));
          write_reg(CFG_SOFTENING, ($urandom_range(0, 3) == 0) ? $urandom
                                                               : $urandom_range(0, 32'h000fffff));
          write_reg(CFG_TIME_STEP, ($urandom_range(0, 4) == 0) ? $urandom
                                                               : $urandom_range(0, 32'h00030000));
        end
      endcase
      n_items = (ph < 2) ? 60 : 230;
      burst = $urandom_range(1, 20);
      for (int k = 0; k < n_items; k++) begin
        j = $urandom_range(0, 99);
        m = (j < 30) ? MODE_LOAD : (j < 65) ? MODE_STAR : (j < 95) ? MODE_BODY : MODE_NONE;
        it = make_item(m, 4'($urandom_range(0, 15)), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord(), rand_mass());
        if (m != MODE_LOAD && count_r != 0 && $urandom_range(0, 1) == 0) begin
          j = $urandom_range(0, ((count_r > MaxAttractors) ? MaxAttractors : count_r) - 1);
          it.pos_x = near(attr_tab[j].pos_x);
          it.pos_y = near(attr_tab[j].pos_y);
          it.pos_z = near(attr_tab[j].pos_z);
          if ($urandom_range(0, 1) == 0) begin
            it.vel_x = 32'($urandom_range(0, 32'h00080000)) - 32'h00040000;
            it.vel_y = 32'($urandom_range(0, 32'h00080000)) - 32'h00040000;
            it.vel_z = 32'($urandom_range(0, 32'h00080000)) - 32'h00040000;
          end
        end
        send(it);
        if (ph != 3) begin
          if (burst == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk_i);
            burst = $urandom_range(1, 20);
          end else begin
            burst--;
          end
        end
      end
    end

    settle();
    repeat (100) @(negedge clk_i);
    mismatches += motion_q.size();
    $display("Covered %0d loads and %0d advances over %0d setting phases; %0d results checked.",
             n_loads, n_advances, n_phases + 1, n_results);
    if (mismatches == 0) begin
      $display("point_gravity_step_tb: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("point_gravity_step_tb: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pgs_pkg.sv
rtl/pgs_ram.sv
rtl/pgs_sqrt.sv
rtl/pgs_div.sv
rtl/point_gravity_step.sv
rtl/pgs_checker.sv
sim/point_gravity_step_tb.sv
